>>> sv/chm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// chm_pkg
// Shared constants, codes and the controller/datapath interface types of the
// chained hash map.
// ----------------------------------------------------------------------------
package chm_pkg;

  localparam int unsigned CapacityDef       = 1024;
  localparam int unsigned MaxBucketsDef     = 2048;
  localparam int unsigned InitialBucketsDef = 8;
  localparam int unsigned KeyWidthDef       = 44;
  localparam int unsigned ValueWidthDef     = 32;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_ERASE  = 2'd1,
    CMD_FIND   = 2'd2,
    CMD_NONE   = 2'd3
  } chm_cmd_e;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_CLEAR,
    OP_START,
    OP_HEAD,
    OP_STEP,
    OP_FIND_HIT,
    OP_REPLACE,
    OP_UNLINK,
    OP_RELEASE,
    OP_FREE_RD,
    OP_LINK_FREE,
    OP_LINK_FRESH,
    OP_FULL,
    OP_CHECK,
    OP_GROW_HEAD,
    OP_GROW_NODE,
    OP_GROW_WB0,
    OP_GROW_WB1
  } chm_op_e;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HEAD,
    ST_WALK,
    ST_LINK_FREE,
    ST_RELEASE,
    ST_CHECK,
    ST_GROW_HEAD,
    ST_GROW_NODE,
    ST_GROW_WB0,
    ST_GROW_WB1,
    ST_DONE
  } chm_state_e;

  typedef struct packed {
    chm_cmd_e cmd;
    logic     cur_nil;
    logic     key_match;
    logic     free_avail;
    logic     fresh_avail;
    logic     grow_need;
    logic     head_nil;
    logic     link_nil;
    logic     grow_last;
    logic     clr_last;
  } chm_stat_t;

endpackage
`default_nettype wire

>>> sv/chained_hash_map.sv
`default_nettype none
// ----------------------------------------------------------------------------
// chained_hash_map
// Key-value map with separate chaining over a node pool, growing its bucket
// table by doubling and rehashing when the load reaches three quarters.
//
//   Channel   Ports                                         Handshake
//   request   cmd_i, key_i, value_i                         start & !busy
//   result    hit_o, found_value_o, entry_total_o, status_o done_o, one cycle
//
// A request reads its bucket head, then walks its chain one node per step
// until a hit or the chain's end. An insert that is not refused also passes
// a load check, and an erase that hits a release step; an insert that reuses
// a released node passes a link step first. A rehash reads each old bucket
// head, splits its chain node by node and writes both halves back. After
// reset the bucket table is cleared, one bucket per cycle, while busy is high.
// Results cannot be stalled; done_o is high for a single cycle.
// ----------------------------------------------------------------------------
module chained_hash_map #(
  parameter int unsigned CAPACITY        = chm_pkg::CapacityDef,
  parameter int unsigned MAX_BUCKETS     = chm_pkg::MaxBucketsDef,
  parameter int unsigned INITIAL_BUCKETS = chm_pkg::InitialBucketsDef,
  parameter int unsigned KEY_WIDTH       = chm_pkg::KeyWidthDef,
  parameter int unsigned VALUE_WIDTH     = chm_pkg::ValueWidthDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    cmd_i,
  input  logic [KEY_WIDTH-1:0]          key_i,
  input  logic [VALUE_WIDTH-1:0]        value_i,
  output logic                          done_o,
  output logic                          hit_o,
  output logic [VALUE_WIDTH-1:0]        found_value_o,
  output logic [$clog2(CAPACITY+1)-1:0] entry_total_o,
  output logic                          status_o
);
  import chm_pkg::*;

  chm_op_e   op;
  chm_stat_t stat;

  chm_ctrl u_ctrl (
    .clk_i, .rst_ni, .start, .busy, .done_o, .op_o(op), .stat_i(stat)
  );

  chm_dp #(
    .CAPACITY(CAPACITY), .MAX_BUCKETS(MAX_BUCKETS),
    .INITIAL_BUCKETS(INITIAL_BUCKETS), .KEY_WIDTH(KEY_WIDTH),
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_dp (
    .clk_i, .rst_ni, .op_i(op), .stat_o(stat), .cmd_i, .key_i, .value_i,
    .hit_o, .found_value_o, .entry_total_o, .status_o
  );

endmodule
`default_nettype wire

>>> sv/chm_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// chm_ram
// Generic single-write, single-read memory with a registered read port.
// ----------------------------------------------------------------------------
module chm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

>>> sv/chm_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// chm_dp
// Datapath of the chained hash map: bucket and node memories, chain walk
// pointers, free list, counters and result registers.
// ----------------------------------------------------------------------------
module chm_dp #(
  parameter int unsigned CAPACITY        = 1024,
  parameter int unsigned MAX_BUCKETS     = 2048,
  parameter int unsigned INITIAL_BUCKETS = 8,
  parameter int unsigned KEY_WIDTH       = 44,
  parameter int unsigned VALUE_WIDTH     = 32
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  chm_pkg::chm_op_e                  op_i,
  output chm_pkg::chm_stat_t                stat_o,
  input  logic [1:0]                        cmd_i,
  input  logic [KEY_WIDTH-1:0]              key_i,
  input  logic [VALUE_WIDTH-1:0]            value_i,
  output logic                              hit_o,
  output logic [VALUE_WIDTH-1:0]            found_value_o,
  output logic [$clog2(CAPACITY+1)-1:0]     entry_total_o,
  output logic                              status_o
);
  import chm_pkg::*;

  localparam int unsigned PW = $clog2(CAPACITY + 1);
  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned BW = $clog2(MAX_BUCKETS);
  localparam int unsigned NW = BW + 1;
  localparam int unsigned XW = (KEY_WIDTH > BW) ? KEY_WIDTH : BW;
  localparam int unsigned LW = PW + NW + 3;
  localparam int unsigned InitCnt = 2 ** $clog2(INITIAL_BUCKETS);
  localparam logic [PW-1:0] Nil = PW'(CAPACITY);

  chm_cmd_e               cmd_q, cmd_d;
  logic [KEY_WIDTH-1:0]   key_q, key_d;
  logic [VALUE_WIDTH-1:0] val_q, val_d;
  logic [PW-1:0]          cur_q, cur_d, prev_q, prev_d, head_q, head_d;
  logic [PW-1:0]          h0_q, h0_d, h1_q, h1_d;
  logic [PW-1:0]          free_q, free_d, fresh_q, fresh_d, count_q, count_d;
  logic [NW-1:0]          cnt_q, cnt_d;
  logic [BW-1:0]          i_q, i_d, clr_q, clr_d;
  logic                   hit_q, hit_d, st_q, st_d;
  logic [VALUE_WIDTH-1:0] fv_q, fv_d;

  logic                   b_we;
  logic [BW-1:0]          b_waddr, b_raddr;
  logic [PW-1:0]          b_wdata, head_rd;
  logic                   key_we, val_we, link_we;
  logic [AW-1:0]          n_waddr, n_raddr;
  logic [PW-1:0]          link_wdata, link_rd;
  logic [KEY_WIDTH-1:0]   key_rd;
  logic [VALUE_WIDTH-1:0] val_rd;
  logic [BW-1:0]          bkt_q, bkt_in, old_b;
  logic [XW-1:0]          mask_x, key_rd_x, old_x;
  logic                   high_bit;
  logic [LW-1:0]          load_lhs, load_rhs;

  function automatic logic [BW-1:0] bucket_of(input logic [KEY_WIDTH-1:0] k,
                                              input logic [XW-1:0] m);
    logic [XW-1:0] kx;
    kx = XW'(k);
    return BW'(kx & m);
  endfunction

  assign mask_x   = XW'(cnt_q - NW'(1));
  assign bkt_q    = bucket_of(key_q, mask_x);
  assign bkt_in   = bucket_of(key_i, mask_x);
  assign old_b    = BW'(cnt_q);
  assign old_x    = XW'(cnt_q);
  assign key_rd_x = XW'(key_rd);
  assign high_bit = |(key_rd_x & old_x);
  assign load_lhs = LW'(count_q) << 2;
  assign load_rhs = (LW'(cnt_q) << 1) + LW'(cnt_q);

  assign stat_o.cmd         = cmd_q;
  assign stat_o.cur_nil     = (cur_q == Nil);
  assign stat_o.key_match   = (key_rd == key_q);
  assign stat_o.free_avail  = (free_q != Nil);
  assign stat_o.fresh_avail = (fresh_q != Nil);
  assign stat_o.grow_need   = (load_lhs >= load_rhs) && (cnt_q <= NW'(MAX_BUCKETS / 2));
  assign stat_o.head_nil    = (head_rd == Nil);
  assign stat_o.link_nil    = (link_rd == Nil);
  assign stat_o.grow_last   = (i_q == BW'(cnt_q - NW'(1)));
  assign stat_o.clr_last    = (clr_q == BW'(MAX_BUCKETS - 1));

  always_comb begin
    cmd_d = cmd_q;  key_d = key_q;  val_d = val_q;
    cur_d = cur_q;  prev_d = prev_q;  head_d = head_q;
    h0_d = h0_q;  h1_d = h1_q;
    free_d = free_q;  fresh_d = fresh_q;  count_d = count_q;  cnt_d = cnt_q;
    i_d = i_q;  clr_d = clr_q;
    hit_d = hit_q;  st_d = st_q;  fv_d = fv_q;
    b_we = 1'b0;  b_waddr = bkt_q;  b_wdata = Nil;  b_raddr = bkt_q;
    key_we = 1'b0;  val_we = 1'b0;  link_we = 1'b0;
    n_waddr = cur_q[AW-1:0];  n_raddr = cur_q[AW-1:0];  link_wdata = head_q;
    unique case (op_i)
      OP_NONE: begin
      end
      OP_CLEAR: begin
        b_we = 1'b1;
        b_waddr = clr_q;
        clr_d = clr_q + BW'(1);
      end
      OP_START: begin
        cmd_d = chm_cmd_e'(cmd_i);
        key_d = key_i;
        val_d = value_i;
        b_raddr = bkt_in;
        hit_d = 1'b0;
        st_d = 1'b0;
        fv_d = '0;
      end
      OP_HEAD: begin
        head_d = head_rd;
        cur_d = head_rd;
        prev_d = Nil;
        n_raddr = head_rd[AW-1:0];
      end
      OP_STEP: begin
        prev_d = cur_q;
        cur_d = link_rd;
        n_raddr = link_rd[AW-1:0];
      end
      OP_FIND_HIT: begin
        hit_d = 1'b1;
        fv_d = val_rd;
      end
      OP_REPLACE: begin
        hit_d = 1'b1;
        val_we = 1'b1;
      end
      OP_UNLINK: begin
        hit_d = 1'b1;
        if (prev_q == Nil) begin
          b_we = 1'b1;
          b_wdata = link_rd;
        end else begin
          link_we = 1'b1;
          n_waddr = prev_q[AW-1:0];
          link_wdata = link_rd;
        end
      end
      OP_RELEASE: begin
        link_we = 1'b1;
        link_wdata = free_q;
        free_d = cur_q;
        count_d = count_q - PW'(1);
      end
      OP_FREE_RD: begin
        n_raddr = free_q[AW-1:0];
      end
      OP_LINK_FREE: begin
        n_waddr = free_q[AW-1:0];
        key_we = 1'b1;
        val_we = 1'b1;
        link_we = 1'b1;
        b_we = 1'b1;
        b_wdata = free_q;
        free_d = link_rd;
        count_d = count_q + PW'(1);
      end
      OP_LINK_FRESH: begin
        n_waddr = fresh_q[AW-1:0];
        key_we = 1'b1;
        val_we = 1'b1;
        link_we = 1'b1;
        b_we = 1'b1;
        b_wdata = fresh_q;
        fresh_d = fresh_q + PW'(1);
        count_d = count_q + PW'(1);
      end
      OP_FULL: begin
        st_d = 1'b1;
      end
      OP_CHECK: begin
        i_d = '0;
        b_raddr = '0;
      end
      OP_GROW_HEAD: begin
        cur_d = head_rd;
        n_raddr = head_rd[AW-1:0];
        h0_d = Nil;
        h1_d = Nil;
      end
      OP_GROW_NODE: begin
        link_we = 1'b1;
        if (high_bit) begin
          link_wdata = h1_q;
          h1_d = cur_q;
        end else begin
          link_wdata = h0_q;
          h0_d = cur_q;
        end
        cur_d = link_rd;
        n_raddr = link_rd[AW-1:0];
      end
      OP_GROW_WB0: begin
        b_we = 1'b1;
        b_waddr = i_q;
        b_wdata = h0_q;
      end
      OP_GROW_WB1: begin
        b_we = 1'b1;
        b_waddr = i_q | old_b;
        b_wdata = h1_q;
        i_d = i_q + BW'(1);
        b_raddr = i_q + BW'(1);
        if (stat_o.grow_last) begin
          cnt_d = cnt_q << 1;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q   <= '0;
      free_q  <= Nil;
      fresh_q <= '0;
      count_q <= '0;
      cnt_q   <= NW'(InitCnt);
    end else begin
      clr_q   <= clr_d;
      free_q  <= free_d;
      fresh_q <= fresh_d;
      count_q <= count_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q  <= cmd_d;
    key_q  <= key_d;
    val_q  <= val_d;
    cur_q  <= cur_d;
    prev_q <= prev_d;
    head_q <= head_d;
    h0_q   <= h0_d;
    h1_q   <= h1_d;
    i_q    <= i_d;
    hit_q  <= hit_d;
    st_q   <= st_d;
    fv_q   <= fv_d;
  end

  chm_ram #(.WIDTH(PW), .DEPTH(MAX_BUCKETS)) u_head_ram (
    .clk_i, .we_i(b_we), .waddr_i(b_waddr), .wdata_i(b_wdata),
    .raddr_i(b_raddr), .rdata_o(head_rd)
  );

  chm_ram #(.WIDTH(KEY_WIDTH), .DEPTH(CAPACITY)) u_key_ram (
    .clk_i, .we_i(key_we), .waddr_i(n_waddr), .wdata_i(key_q),
    .raddr_i(n_raddr), .rdata_o(key_rd)
  );

  chm_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(CAPACITY)) u_val_ram (
    .clk_i, .we_i(val_we), .waddr_i(n_waddr), .wdata_i(val_q),
    .raddr_i(n_raddr), .rdata_o(val_rd)
  );

  chm_ram #(.WIDTH(PW), .DEPTH(CAPACITY)) u_link_ram (
    .clk_i, .we_i(link_we), .waddr_i(n_waddr), .wdata_i(link_wdata),
    .raddr_i(n_raddr), .rdata_o(link_rd)
  );

  assign hit_o         = hit_q;
  assign found_value_o = fv_q;
  assign entry_total_o = count_q;
  assign status_o      = st_q;

endmodule
`default_nettype wire

>>> sv/chm_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// chm_ctrl
// Controller of the chained hash map: sequences the bucket clear, the chain
// walk, the insert and erase updates and the rehash.
// ----------------------------------------------------------------------------
module chm_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  output logic               done_o,
  output chm_pkg::chm_op_e   op_o,
  input  chm_pkg::chm_stat_t stat_i
);
  import chm_pkg::*;

  chm_state_e state_q, state_d;
  logic       hit;

  assign hit = !stat_i.cur_nil && stat_i.key_match;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR:     if (stat_i.clr_last) state_d = ST_IDLE;
      ST_IDLE:      if (start) state_d = ST_HEAD;
      ST_HEAD:      state_d = ST_WALK;
      ST_WALK: begin
        if (hit) begin
          unique case (stat_i.cmd)
            CMD_INSERT: state_d = ST_CHECK;
            CMD_ERASE:  state_d = ST_RELEASE;
            CMD_FIND:   state_d = ST_DONE;
            CMD_NONE:   state_d = ST_DONE;
          endcase
        end else if (!stat_i.cur_nil) begin
          state_d = ST_WALK;
        end else if (stat_i.cmd == CMD_INSERT) begin
          priority if (stat_i.free_avail) state_d = ST_LINK_FREE;
          else if (stat_i.fresh_avail)    state_d = ST_CHECK;
          else                            state_d = ST_DONE;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_LINK_FREE: state_d = ST_CHECK;
      ST_RELEASE:   state_d = ST_DONE;
      ST_CHECK:     state_d = stat_i.grow_need ? ST_GROW_HEAD : ST_DONE;
      ST_GROW_HEAD: state_d = stat_i.head_nil ? ST_GROW_WB0 : ST_GROW_NODE;
      ST_GROW_NODE: if (stat_i.link_nil) state_d = ST_GROW_WB0;
      ST_GROW_WB0:  state_d = ST_GROW_WB1;
      ST_GROW_WB1:  state_d = stat_i.grow_last ? ST_DONE : ST_GROW_HEAD;
      ST_DONE:      state_d = ST_IDLE;
      default:      state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    op_o   = OP_NONE;
    busy   = (state_q != ST_IDLE);
    done_o = (state_q == ST_DONE);
    unique case (state_q)
      ST_CLEAR:     op_o = OP_CLEAR;
      ST_IDLE:      if (start) op_o = OP_START;
      ST_HEAD:      op_o = OP_HEAD;
      ST_WALK: begin
        if (hit) begin
          unique case (stat_i.cmd)
            CMD_INSERT: op_o = OP_REPLACE;
            CMD_ERASE:  op_o = OP_UNLINK;
            CMD_FIND:   op_o = OP_FIND_HIT;
            CMD_NONE:   op_o = OP_NONE;
          endcase
        end else if (!stat_i.cur_nil) begin
          op_o = OP_STEP;
        end else if (stat_i.cmd == CMD_INSERT) begin
          priority if (stat_i.free_avail) op_o = OP_FREE_RD;
          else if (stat_i.fresh_avail)    op_o = OP_LINK_FRESH;
          else                            op_o = OP_FULL;
        end
      end
      ST_LINK_FREE: op_o = OP_LINK_FREE;
      ST_RELEASE:   op_o = OP_RELEASE;
      ST_CHECK:     op_o = OP_CHECK;
      ST_GROW_HEAD: op_o = OP_GROW_HEAD;
      ST_GROW_NODE: op_o = OP_GROW_NODE;
      ST_GROW_WB0:  op_o = OP_GROW_WB0;
      ST_GROW_WB1:  op_o = OP_GROW_WB1;
      ST_DONE:      op_o = OP_NONE;
      default:      op_o = OP_NONE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
`default_nettype wire
